>>> sv/wpl_pkg.sv
// ----------------------------------------------------------------------------
// wpl_pkg
// Shared types and constants for the serial pixel line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wpl_pkg;

   localparam int unsigned PIXEL_BITS = 24;
   localparam int unsigned BITS_W     = 5;
   localparam int unsigned BIT_TIME_W = 10;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH_GAP = 3'd4;

   localparam logic [BIT_TIME_W-1:0] RST_ONE_HIGH  = 10'd6;
   localparam logic [BIT_TIME_W-1:0] RST_ONE_LOW   = 10'd3;
   localparam logic [BIT_TIME_W-1:0] RST_ZERO_HIGH = 10'd2;
   localparam logic [BIT_TIME_W-1:0] RST_ZERO_LOW  = 10'd6;
   localparam logic [TICK_W-1:0]     RST_LATCH_GAP = 16'd400;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef struct packed {
      logic [BIT_TIME_W-1:0] one_high;
      logic [BIT_TIME_W-1:0] one_low;
      logic [BIT_TIME_W-1:0] zero_high;
      logic [BIT_TIME_W-1:0] zero_low;
      logic [TICK_W-1:0]     latch_gap;
   } cfg_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } item_type;

   typedef struct packed {
      logic line_level;
      logic can_accept;
      logic frame_done;
      logic load_dropped;
   } result_type;

endpackage

`default_nettype wire

>>> sv/wpl_csr.sv
// ----------------------------------------------------------------------------
// wpl_csr
// Timing registers of the encoder, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module wpl_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [wpl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wpl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output wpl_pkg::cfg_type                      cfg
);

   wpl_pkg::cfg_type cfg_ff;
   wpl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            wpl_pkg::CSR_ONE_HIGH:  cfg_in.one_high  = csr_wdata[wpl_pkg::BIT_TIME_W-1:0];
            wpl_pkg::CSR_ONE_LOW:   cfg_in.one_low   = csr_wdata[wpl_pkg::BIT_TIME_W-1:0];
            wpl_pkg::CSR_ZERO_HIGH: cfg_in.zero_high = csr_wdata[wpl_pkg::BIT_TIME_W-1:0];
            wpl_pkg::CSR_ZERO_LOW:  cfg_in.zero_low  = csr_wdata[wpl_pkg::BIT_TIME_W-1:0];
            wpl_pkg::CSR_LATCH_GAP: cfg_in.latch_gap = csr_wdata[wpl_pkg::TICK_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high  <= wpl_pkg::RST_ONE_HIGH;
         cfg_ff.one_low   <= wpl_pkg::RST_ONE_LOW;
         cfg_ff.zero_high <= wpl_pkg::RST_ZERO_HIGH;
         cfg_ff.zero_low  <= wpl_pkg::RST_ZERO_LOW;
         cfg_ff.latch_gap <= wpl_pkg::RST_LATCH_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/wpl_core.sv
// ----------------------------------------------------------------------------
// wpl_core
// Bit timing state machine, shifter and holding register. One item is
// applied per step; the result is produced combinationally for registering.
// ----------------------------------------------------------------------------
`default_nettype none

module wpl_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire wpl_pkg::item_type   item,
   input  wire wpl_pkg::cfg_type    cfg,
   output wpl_pkg::result_type      result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HIGH,
      PH_LOW,
      PH_GAP
   } phase_type;

   phase_type                                phase_ff, phase_in;
   logic [wpl_pkg::TICK_W-1:0]               tick_ff, tick_in;
   logic [wpl_pkg::PIXEL_BITS-1:0]           shift_ff, shift_in;
   logic [wpl_pkg::BITS_W-1:0]               bits_ff, bits_in;
   logic                                     sh_last_ff, sh_last_in;
   logic [wpl_pkg::PIXEL_BITS-1:0]           held_ff, held_in;
   logic                                     held_valid_ff, held_valid_in;
   logic                                     held_last_ff, held_last_in;
   logic                                     level, done, dropped;

   function automatic logic [wpl_pkg::TICK_W-1:0] min_one(
      input logic [wpl_pkg::TICK_W-1:0] v
   );
      return (v == '0) ? wpl_pkg::TICK_W'(1) : v;
   endfunction

   function automatic logic [wpl_pkg::TICK_W-1:0] high_time(
      input logic                       msb,
      input wpl_pkg::cfg_type           c
   );
      return min_one(wpl_pkg::TICK_W'(msb ? c.one_high : c.zero_high));
   endfunction

   function automatic logic [wpl_pkg::TICK_W-1:0] low_time(
      input logic                       msb,
      input wpl_pkg::cfg_type           c
   );
      return min_one(wpl_pkg::TICK_W'(msb ? c.one_low : c.zero_low));
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      shift_in      = shift_ff;
      bits_in       = bits_ff;
      sh_last_in    = sh_last_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      held_last_in  = held_last_ff;
      level         = 1'b0;
      done          = 1'b0;
      dropped       = 1'b0;

      if (item.opcode == wpl_pkg::OP_LOAD) begin
         if (held_valid_ff) begin
            dropped = 1'b1;
         end else begin
            held_in       = {item.green, item.red, item.blue};
            held_last_in  = item.last_pixel;
            held_valid_in = 1'b1;
         end
         level = (phase_ff == PH_HIGH);
      end else begin
         // take the held pixel on an idle tick
         if (phase_ff == PH_IDLE && held_valid_ff) begin
            shift_in      = held_ff;
            sh_last_in    = held_last_ff;
            held_valid_in = 1'b0;
            held_last_in  = 1'b0;
            bits_in       = wpl_pkg::BITS_W'(wpl_pkg::PIXEL_BITS);
            phase_in      = PH_HIGH;
            tick_in       = high_time(held_ff[wpl_pkg::PIXEL_BITS-1], cfg);
         end
         if (phase_in != PH_IDLE) begin
            level = (phase_in == PH_HIGH);
            if (tick_in != '0) begin
               tick_in = tick_in - 1'b1;
            end
            if (tick_in == '0) begin
               unique case (phase_in)
                  PH_HIGH: begin
                     phase_in = PH_LOW;
                     tick_in  = low_time(shift_in[wpl_pkg::PIXEL_BITS-1], cfg);
                  end
                  PH_LOW: begin
                     shift_in = {shift_in[wpl_pkg::PIXEL_BITS-2:0], 1'b0};
                     if (bits_in != '0) begin
                        bits_in = bits_in - 1'b1;
                     end
                     if (bits_in != '0) begin
                        phase_in = PH_HIGH;
                        tick_in  = high_time(shift_in[wpl_pkg::PIXEL_BITS-1], cfg);
                     end else if (sh_last_in) begin
                        sh_last_in = 1'b0;
                        phase_in   = PH_GAP;
                        tick_in    = min_one(cfg.latch_gap);
                     end else if (held_valid_in) begin
                        shift_in      = held_ff;
                        sh_last_in    = held_last_ff;
                        held_valid_in = 1'b0;
                        held_last_in  = 1'b0;
                        bits_in       = wpl_pkg::BITS_W'(wpl_pkg::PIXEL_BITS);
                        phase_in      = PH_HIGH;
                        tick_in       = high_time(held_ff[wpl_pkg::PIXEL_BITS-1], cfg);
                     end else begin
                        phase_in = PH_IDLE;
                        tick_in  = '0;
                     end
                  end
                  PH_GAP: begin
                     done = 1'b1;
                     if (held_valid_in) begin
                        shift_in      = held_ff;
                        sh_last_in    = held_last_ff;
                        held_valid_in = 1'b0;
                        held_last_in  = 1'b0;
                        bits_in       = wpl_pkg::BITS_W'(wpl_pkg::PIXEL_BITS);
                        phase_in      = PH_HIGH;
                        tick_in       = high_time(held_ff[wpl_pkg::PIXEL_BITS-1], cfg);
                     end else begin
                        phase_in = PH_IDLE;
                        tick_in  = '0;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     tick_in  = '0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         shift_ff      <= '0;
         bits_ff       <= '0;
         sh_last_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         held_last_ff  <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         shift_ff      <= shift_in;
         bits_ff       <= bits_in;
         sh_last_ff    <= sh_last_in;
         held_valid_ff <= held_valid_in;
         held_last_ff  <= held_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         held_ff <= held_in;
      end
   end

   assign result = '{line_level:   level,
                     can_accept:   !held_valid_in,
                     frame_done:   done,
                     load_dropped: dropped};

   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_ff == '0))
      else $error("idle phase with ticks pending");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (tick_ff != '0))
      else $error("active phase with empty tick count");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= wpl_pkg::BITS_W'(wpl_pkg::PIXEL_BITS))
      else $error("bit counter beyond pixel size");

   a_load_holds: assert property (@(posedge clock) disable iff (reset)
      (step && item.opcode == wpl_pkg::OP_LOAD && !held_valid_ff) |=> held_valid_ff)
      else $error("accepted load not held");

   a_done_in_gap: assert property (@(posedge clock) disable iff (reset)
      (step && done) |-> (phase_ff == PH_GAP))
      else $error("frame done outside latch gap");

endmodule

`default_nettype wire

>>> sv/ws2812_pixel_line_encoder.sv
// ----------------------------------------------------------------------------
// ws2812_pixel_line_encoder
// Serial LED line encoder: pixel loads and ticks in, one line sample out.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  opcode, red, green, blue, last_pixel
//   rsp      out  rsp_valid/rsp_stall  line_level, can_accept, frame_done,
//                                      load_dropped
//   csr      in   csr_write            csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low; an accepted item reaches rsp
// through the input register, then the result register.
// The state update runs in one pass between the two registers.
// Reset is synchronous and clears all control state and the timing registers.
// A rsp stall holds the result register and backs up through the input
// register; req_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module ws2812_pixel_line_encoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic                             req_opcode,
   input  wire logic [7:0]                       req_red,
   input  wire logic [7:0]                       req_green,
   input  wire logic [7:0]                       req_blue,
   input  wire logic                             req_last_pixel,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic                             rsp_line_level,
   output      logic                             rsp_can_accept,
   output      logic                             rsp_frame_done,
   output      logic                             rsp_load_dropped,
   input  wire logic                             csr_write,
   input  wire logic [wpl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wpl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   wpl_pkg::cfg_type     cfg;
   wpl_pkg::item_type    in_item_ff;
   wpl_pkg::result_type  result;
   wpl_pkg::result_type  rsp_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 req_take;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = (in_valid_ff && advance) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{opcode:     req_opcode,
                         red:        req_red,
                         green:      req_green,
                         blue:       req_blue,
                         last_pixel: req_last_pixel};
      end
      if (in_valid_ff && advance) begin
         rsp_ff <= result;
      end
   end

   wpl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wpl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (in_valid_ff && advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_level   = rsp_ff.line_level;
   assign rsp_can_accept   = rsp_ff.can_accept;
   assign rsp_frame_done   = rsp_ff.frame_done;
   assign rsp_load_dropped = rsp_ff.load_dropped;

endmodule

`default_nettype wire
